// ===== rtl/swept_aabb_move_clamp_macros.svh =====
// assertion macros for the swept box move clamp
// clocked on clk_i, disabled while rst_ni is low
`ifndef SWEPT_AABB_MOVE_CLAMP_MACROS_SVH
`define SWEPT_AABB_MOVE_CLAMP_MACROS_SVH

`define SAMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SAMC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/samc_pkg.sv =====
// shared types and constants of the swept box move clamp
// no dependencies
package samc_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TIME_BITS  = 16;
  localparam int unsigned TOL_BITS   = 16;
  localparam int unsigned TOL_RESET  = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int unsigned AXES       = 3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  localparam logic [2:0] OUT_KEEP    = 3'd0;
  localparam logic [2:0] OUT_CLAMP_X = 3'd1;
  localparam logic [2:0] OUT_CLAMP_Y = 3'd2;
  localparam logic [2:0] OUT_CLAMP_Z = 3'd3;
  localparam logic [2:0] OUT_REVERSE = 3'd4;

  typedef enum logic [1:0] {
    AX_NEVER   = 2'd0,
    AX_OVERLAP = 2'd1,
    AX_TIME    = 2'd2
  } axis_kind_e;

  typedef struct packed {
    logic                          action;
    logic signed [COORD_BITS-1:0]  box_min_x;
    logic signed [COORD_BITS-1:0]  box_min_y;
    logic signed [COORD_BITS-1:0]  box_min_z;
    logic signed [COORD_BITS-1:0]  box_max_x;
    logic signed [COORD_BITS-1:0]  box_max_y;
    logic signed [COORD_BITS-1:0]  box_max_z;
    logic signed [COORD_BITS-1:0]  move_x;
    logic signed [COORD_BITS-1:0]  move_y;
    logic signed [COORD_BITS-1:0]  move_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic signed [COORD_BITS-1:0]  out_z;
    logic [2:0]                    outcome;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic prep;
    logic div_step;
    logic pick;
    logic mul;
    logic fin;
  } samc_cmd_t;

endpackage

// ===== rtl/samc_dp.sv =====
// datapath: mover box, per-axis restoring dividers, clamp multiply, result register
// depends on samc_pkg
module samc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  samc_pkg::samc_cmd_t           cmd_i,
  input  samc_pkg::in_beat_t            in_beat_i,
  input  logic                          cfg_we_i,
  input  logic [samc_pkg::TOL_BITS-1:0] cfg_data_i,
  output samc_pkg::out_beat_t           out_beat_o
);

  localparam int unsigned CW = samc_pkg::COORD_BITS;
  localparam int unsigned TB = samc_pkg::TIME_BITS;
  localparam int unsigned NA = samc_pkg::AXES;

  logic [CW-1:0] mover_min_q [NA];
  logic [CW-1:0] mover_max_q [NA];
  logic [CW-1:0] omn_q [NA];
  logic [CW-1:0] omx_q [NA];
  logic [CW-1:0] mv_q [NA];
  logic [CW-1:0] in_min [NA];
  logic [CW-1:0] in_max [NA];
  logic [CW-1:0] in_mv [NA];

  logic [samc_pkg::TOL_BITS-1:0] tol_q;

  samc_pkg::axis_kind_e kind_q [NA];
  samc_pkg::axis_kind_e kind_d [NA];
  logic [CW-1:0] den_q [NA];
  logic [CW-1:0] den_d [NA];
  logic [CW:0]   rem_q [NA];
  logic [CW:0]   rem_d [NA];
  logic [TB-1:0] quo_q [NA];
  logic [TB-1:0] quo_d [NA];
  logic          hit_q, hit_d;

  logic signed [CW:0] mn_w [NA];
  logic signed [CW:0] mx_w [NA];
  logic signed [CW:0] omn_w [NA];
  logic signed [CW:0] omx_w [NA];
  logic signed [CW:0] mv_w [NA];
  logic signed [CW:0] a_w [NA];
  logic signed [CW:0] b_w [NA];
  logic signed [CW:0] smn_w [NA];
  logic signed [CW:0] smx_w [NA];
  logic signed [CW:0] num_a_w [NA];
  logic signed [CW:0] num_b_w [NA];
  logic signed [CW:0] neg_mv_w [NA];
  logic [CW:0]        sh_w [NA];

  logic [2:0]    outcome_q, outcome_d;
  logic [CW-1:0] mag_q, mag_d;
  logic [TB-1:0] t_q, t_d;
  logic          neg_q, neg_d;
  logic          never_any;
  logic [NA-1:0] best;
  logic [CW-1:0] mv_sel;
  logic [1:0]    sel_idx;

  logic [CW+TB-1:0] prod_q;
  logic [CW-1:0]    p_w, p_cl, p_res;
  logic [CW-1:0]    res_w [NA];
  samc_pkg::out_beat_t out_q, out_d;

  assign in_min = '{in_beat_i.box_min_x, in_beat_i.box_min_y, in_beat_i.box_min_z};
  assign in_max = '{in_beat_i.box_max_x, in_beat_i.box_max_y, in_beat_i.box_max_z};
  assign in_mv  = '{in_beat_i.move_x, in_beat_i.move_y, in_beat_i.move_z};

  // per-axis sweep test, overlap, division setup and restoring division steps
  always_comb begin
    hit_d = 1'b1;
    for (int i = 0; i < NA; i++) begin
      mn_w[i]     = signed'({mover_min_q[i][CW-1], mover_min_q[i]});
      mx_w[i]     = signed'({mover_max_q[i][CW-1], mover_max_q[i]});
      omn_w[i]    = signed'({omn_q[i][CW-1], omn_q[i]});
      omx_w[i]    = signed'({omx_q[i][CW-1], omx_q[i]});
      mv_w[i]     = signed'({mv_q[i][CW-1], mv_q[i]});
      a_w[i]      = mn_w[i] + mv_w[i];
      b_w[i]      = mx_w[i] + mv_w[i];
      smn_w[i]    = (a_w[i] < b_w[i]) ? a_w[i] : b_w[i];
      smn_w[i]    = (mn_w[i] < smn_w[i]) ? mn_w[i] : smn_w[i];
      smx_w[i]    = (a_w[i] > b_w[i]) ? a_w[i] : b_w[i];
      smx_w[i]    = (mx_w[i] > smx_w[i]) ? mx_w[i] : smx_w[i];
      num_a_w[i]  = omn_w[i] - mx_w[i];
      num_b_w[i]  = mn_w[i] - omx_w[i];
      neg_mv_w[i] = -mv_w[i];
      if (smx_w[i] <= omn_w[i] || smn_w[i] >= omx_w[i]) begin
        hit_d = 1'b0;
      end
      kind_d[i] = samc_pkg::AX_NEVER;
      den_d[i]  = neg_mv_w[i][CW-1:0];
      rem_d[i]  = num_b_w[i];
      if (mx_w[i] > omn_w[i] && mn_w[i] < omx_w[i]) begin
        kind_d[i] = samc_pkg::AX_OVERLAP;
      end else if (mx_w[i] <= omn_w[i] && b_w[i] > omn_w[i]) begin
        kind_d[i] = samc_pkg::AX_TIME;
        den_d[i]  = mv_q[i];
        rem_d[i]  = num_a_w[i];
      end else if (mn_w[i] >= omx_w[i] && a_w[i] < omx_w[i]) begin
        kind_d[i] = samc_pkg::AX_TIME;
      end
      quo_d[i] = '0;
      sh_w[i]  = {rem_q[i][CW-1:0], 1'b0};
      if (cmd_i.div_step) begin
        if (sh_w[i] >= {1'b0, den_q[i]}) begin
          rem_d[i] = sh_w[i] - {1'b0, den_q[i]};
          quo_d[i] = {quo_q[i][TB-2:0], 1'b1};
        end else begin
          rem_d[i] = sh_w[i];
          quo_d[i] = {quo_q[i][TB-2:0], 1'b0};
        end
      end
    end
  end

  // axis choice: latest time of impact, x first on ties
  always_comb begin
    never_any = 1'b0;
    for (int i = 0; i < NA; i++) begin
      if (kind_q[i] == samc_pkg::AX_NEVER) begin
        never_any = 1'b1;
      end
      best[i] = (kind_q[i] == samc_pkg::AX_TIME);
      for (int j = 0; j < NA; j++) begin
        if (kind_q[j] == samc_pkg::AX_TIME && quo_q[i] < quo_q[j]) begin
          best[i] = 1'b0;
        end
      end
    end
    sel_idx   = 2'd0;
    outcome_d = samc_pkg::OUT_REVERSE;
    if (!hit_q || never_any) begin
      outcome_d = samc_pkg::OUT_KEEP;
    end else if (best[0]) begin
      outcome_d = samc_pkg::OUT_CLAMP_X;
    end else if (best[1]) begin
      outcome_d = samc_pkg::OUT_CLAMP_Y;
      sel_idx   = 2'd1;
    end else if (best[2]) begin
      outcome_d = samc_pkg::OUT_CLAMP_Z;
      sel_idx   = 2'd2;
    end
    mv_sel = mv_q[sel_idx];
    t_d    = quo_q[sel_idx];
    neg_d  = mv_sel[CW-1];
    mag_d  = neg_d ? (~mv_sel + 1'b1) : mv_sel;
  end

  // result assembly
  always_comb begin
    p_w   = prod_q[CW+TB-1:TB];
    p_cl  = (p_w > {{(CW-samc_pkg::TOL_BITS){1'b0}}, tol_q})
            ? p_w - {{(CW-samc_pkg::TOL_BITS){1'b0}}, tol_q} : '0;
    p_res = neg_q ? (~p_cl + 1'b1) : p_cl;
    for (int i = 0; i < NA; i++) begin
      res_w[i] = mv_q[i];
      if (outcome_q == samc_pkg::OUT_REVERSE) begin
        res_w[i] = (mv_q[i] == {1'b1, {(CW-1){1'b0}}}) ? {1'b0, {(CW-1){1'b1}}}
                                                        : (~mv_q[i] + 1'b1);
      end
    end
    case (outcome_q)
      samc_pkg::OUT_CLAMP_X: res_w[0] = p_res;
      samc_pkg::OUT_CLAMP_Y: res_w[1] = p_res;
      samc_pkg::OUT_CLAMP_Z: res_w[2] = p_res;
      default: ;
    endcase
    out_d.out_x   = res_w[0];
    out_d.out_y   = res_w[1];
    out_d.out_z   = res_w[2];
    out_d.outcome = outcome_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= samc_pkg::TOL_BITS'(samc_pkg::TOL_RESET);
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      if (cmd_i.load) begin
        mover_min_q[i] <= in_min[i];
        mover_max_q[i] <= in_max[i];
      end
      if (cmd_i.capture) begin
        omn_q[i] <= in_min[i];
        omx_q[i] <= in_max[i];
        mv_q[i]  <= in_mv[i];
      end
      if (cmd_i.prep) begin
        kind_q[i] <= kind_d[i];
        den_q[i]  <= den_d[i];
      end
      if (cmd_i.prep || cmd_i.div_step) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
    if (cmd_i.prep) begin
      hit_q <= hit_d;
    end
    if (cmd_i.pick) begin
      outcome_q <= outcome_d;
      mag_q     <= mag_d;
      t_q       <= t_d;
      neg_q     <= neg_d;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * t_q;
    end
    if (cmd_i.fin) begin
      out_q <= out_d;
    end
  end

  assign out_beat_o = out_q;

endmodule

// ===== rtl/samc_ctrl.sv =====
// controller: sequencing of load and test, division count, output beat valid
// depends on samc_pkg and swept_aabb_move_clamp_macros.svh
`include "swept_aabb_move_clamp_macros.svh"

module samc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output samc_pkg::samc_cmd_t cmd_o
);

  localparam int unsigned CNT_BITS = $clog2(samc_pkg::TIME_BITS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_PICK = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.load    = accept && (in_action_i == samc_pkg::ACT_LOAD);
    cmd_o.capture = accept && (in_action_i == samc_pkg::ACT_TEST);
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(samc_pkg::TIME_BITS - 1)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SAMC_NEVER(a_fin_no_overwrite, cmd_o.fin && out_valid_q && out_stall_i, "result overwritten")
  `SAMC_ASSERT(a_div_done, (state_q == ST_DIV) && (cnt_q == CNT_BITS'(samc_pkg::TIME_BITS - 1)) |=> (state_q == ST_PICK), "division count off")
  `SAMC_ASSERT(a_valid_from_fin, $rose(out_valid_q) |-> $past(state_q == ST_FIN), "result without finish")

endmodule

// ===== rtl/swept_aabb_move_clamp.sv =====
// top level of the swept box move clamp: controller and datapath
// depends on samc_pkg, samc_ctrl, samc_dp
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   in_beat_i (samc_pkg::in_beat_t)
// out      out  out_valid_o / out_stall_i out_beat_o (samc_pkg::out_beat_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (tolerance)
//
// a load beat leaves the controller idle, so the next beat can follow it; a test beat
// runs through prep, divide, pick, multiply and finish before the next beat is taken
// time is set by the 16-step restoring dividers, one per axis, run in parallel
// reset clears controller and output valid, sets tolerance to 66; mover box undefined
// a stalled result holds in the output register; the next beat is taken meanwhile
module swept_aabb_move_clamp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  samc_pkg::in_beat_t            in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output samc_pkg::out_beat_t           out_beat_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [samc_pkg::TOL_BITS-1:0] cfg_data_i
);

  samc_pkg::samc_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  samc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_beat_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  samc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_beat_i  (in_beat_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_beat_o (out_beat_o)
  );

endmodule

// ===== verif/tb_swept_aabb_move_clamp.sv =====
// testbench for the swept box move clamp: random and directed load/test beats
// scoreboard class predicts each adjusted move; depends on samc_pkg and the rtl top
module tb_swept_aabb_move_clamp;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] wide_t;

  class move_scoreboard;
    wide_t mov_lo[3];
    wide_t mov_hi[3];
    logic [15:0] stand_off;
    samc_pkg::out_beat_t pending[$];
    int mismatches;
    int checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        mov_lo[i] = 0;
        mov_hi[i] = 0;
      end
      stand_off = 16'(samc_pkg::TOL_RESET);
      mismatches = 0;
      checked = 0;
    endfunction

    function wide_t toi_quot(wide_t num, wide_t den);
      logic [63:0] q;
      logic [63:0] r;
      q = 0;
      r = num;
      for (int i = 0; i < samc_pkg::TIME_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      return wide_t'(q);
    endfunction

    function wide_t axis_toi(wide_t mn, wide_t mx, wide_t omn, wide_t omx, wide_t mv);
      if (mx > omn && mn < omx) return -65536;
      if (mx <= omn && mx + mv > omn) return toi_quot(omn - mx, mv);
      if (mn >= omx && mn + mv < omx) return toi_quot(mn - omx, -mv);
      return 131072;
    endfunction

    function void note_beat(samc_pkg::in_beat_t b);
      wide_t omn[3], omx[3], mv[3], t[3], res[3];
      wide_t a, c, smn, smx, mag, p;
      logic hit;
      logic [2:0] oc;
      int sel;
      samc_pkg::out_beat_t e;
      omn[0] = b.box_min_x; omn[1] = b.box_min_y; omn[2] = b.box_min_z;
      omx[0] = b.box_max_x; omx[1] = b.box_max_y; omx[2] = b.box_max_z;
      mv[0] = b.move_x; mv[1] = b.move_y; mv[2] = b.move_z;
      if (b.action == samc_pkg::ACT_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          mov_lo[i] = omn[i];
          mov_hi[i] = omx[i];
        end
        return;
      end
      hit = 1'b1;
      oc = samc_pkg::OUT_KEEP;
      for (int i = 0; i < 3; i++) begin
        a = mov_lo[i] + mv[i];
        c = mov_hi[i] + mv[i];
        smn = mov_lo[i]; if (a < smn) smn = a; if (c < smn) smn = c;
        smx = mov_hi[i]; if (a > smx) smx = a; if (c > smx) smx = c;
        if (smx <= omn[i] || smn >= omx[i]) hit = 1'b0;
        res[i] = mv[i];
      end
      if (hit) begin
        for (int i = 0; i < 3; i++) t[i] = axis_toi(mov_lo[i], mov_hi[i], omn[i], omx[i], mv[i]);
        if (!(t[0] > 65536 || t[1] > 65536 || t[2] > 65536)) begin
          sel = -1;
          for (int i = 0; i < 3; i++)
            if (sel < 0 && t[i] >= 0 && t[i] >= t[0] && t[i] >= t[1] && t[i] >= t[2]) sel = i;
          if (sel >= 0) begin
            mag = mv[sel] < 0 ? -mv[sel] : mv[sel];
            p = (mag * t[sel]) >>> 16;
            p = p > stand_off ? p - stand_off : 0;
            res[sel] = mv[sel] < 0 ? -p : p;
            oc = 3'(sel + 1);
          end else begin
            for (int i = 0; i < 3; i++) res[i] = mv[i] < -64'sd2147483647 ? 64'sd2147483647 : -mv[i];
            oc = samc_pkg::OUT_REVERSE;
          end
        end
      end
      e.out_x = res[0][31:0];
      e.out_y = res[1][31:0];
      e.out_z = res[2][31:0];
      e.outcome = oc;
      pending.push_back(e);
    endfunction

    function void check_beat(samc_pkg::out_beat_t got);
      samc_pkg::out_beat_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.out_x !== e.out_x || got.out_y !== e.out_y || got.out_z !== e.out_z ||
          got.outcome !== e.outcome) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %0d got %h %h %h %0d", e.out_x, e.out_y, e.out_z,
                   e.outcome, got.out_x, got.out_y, got.out_z, got.outcome);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_valid_i, cfg_ready_o;
  samc_pkg::in_beat_t in_beat_i;
  samc_pkg::out_beat_t out_beat_o;
  logic [samc_pkg::TOL_BITS-1:0] cfg_data_i;
  move_scoreboard sb;
  int long_hold;
  int hold_reqs;
  int hold_seen;
  int n_loads, n_tests;

  swept_aabb_move_clamp dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_beat_o(out_beat_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver side with random stalls and requested long holds
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      long_hold <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) sb.check_beat(out_beat_o);
      if (long_hold > 0) begin
        out_stall_i <= 1'b1;
        long_hold <= long_hold - 1;
      end else if (hold_seen != hold_reqs) begin
        out_stall_i <= 1'b1;
        long_hold <= 199;
        hold_seen <= hold_reqs;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic send_beat(samc_pkg::in_beat_t b);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(b);
    if (b.action == samc_pkg::ACT_LOAD) n_loads++; else n_tests++;
  endtask

  task automatic drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.stand_off = v;
  endtask

  function automatic logic [31:0] rand_coord(int span);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_fffc + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic samc_pkg::in_beat_t make_box(logic act, int span);
    samc_pkg::in_beat_t b;
    logic signed [31:0] lo, sz;
    b.action = act;
    if ($urandom_range(0, 9) == 0) begin
      b.box_min_x = rand_coord(span); b.box_min_y = rand_coord(span);
      b.box_min_z = rand_coord(span); b.box_max_x = rand_coord(span);
      b.box_max_y = rand_coord(span); b.box_max_z = rand_coord(span);
    end else begin
      lo = $signed($urandom_range(0, 2 * span)) - span; sz = $urandom_range(1, span / 2);
      b.box_min_x = lo; b.box_max_x = lo + sz;
      lo = $signed($urandom_range(0, 2 * span)) - span; sz = $urandom_range(1, span / 2);
      b.box_min_y = lo; b.box_max_y = lo + sz;
      lo = $signed($urandom_range(0, 2 * span)) - span; sz = $urandom_range(1, span / 2);
      b.box_min_z = lo; b.box_max_z = lo + sz;
    end
    if ($urandom_range(0, 7) == 0) begin
      b.move_x = rand_coord(span); b.move_y = rand_coord(span); b.move_z = rand_coord(span);
    end else begin
      b.move_x = $signed($urandom_range(0, 4 * span)) - 2 * span;
      b.move_y = $signed($urandom_range(0, 4 * span)) - 2 * span;
      b.move_z = $signed($urandom_range(0, 4 * span)) - 2 * span;
    end
    return b;
  endfunction

  function automatic samc_pkg::in_beat_t cube(logic act, int lo, int hi, int mx, int my,
                                              int mz);
    samc_pkg::in_beat_t b;
    b.action = act;
    b.box_min_x = lo; b.box_min_y = lo; b.box_min_z = lo;
    b.box_max_x = hi; b.box_max_y = hi; b.box_max_z = hi;
    b.move_x = mx; b.move_y = my; b.move_z = mz;
    return b;
  endfunction

  initial begin
    samc_pkg::in_beat_t b;
    int span;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_beat_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hold_reqs = 0;
    n_loads = 0;
    n_tests = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss, x/y/z hits, touching faces, overlap reversal, extremes
    send_beat(cube(samc_pkg::ACT_LOAD, 0, 65536, 0, 0, 0));
    send_beat(cube(samc_pkg::ACT_TEST, 1000000, 1065536, 10, 10, 10));
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_x = 131072; b.box_max_x = 196608; b.move_x = 131072;
    send_beat(b);
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_y = -131072; b.box_max_y = -65536; b.move_y = -100000;
    send_beat(b);
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_z = 65600; b.box_max_z = 200000; b.move_z = 80;
    send_beat(b);
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_x = 65536; b.box_max_x = 131072; b.move_x = 0;
    send_beat(b);
    send_beat(cube(samc_pkg::ACT_TEST, 100, 200, 5, -7, 9));
    send_beat(cube(samc_pkg::ACT_TEST, 100, 200, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_x = 70000; b.box_max_x = 90000; b.move_x = 65536;
    b.box_min_y = 70000; b.box_max_y = 90000; b.move_y = 65536;
    send_beat(b);
    send_beat(cube(samc_pkg::ACT_LOAD, 65536, 0, 0, 0, 0));
    send_beat(cube(samc_pkg::ACT_TEST, -100, 100, 1000, -1000, 3));
    send_beat(cube(samc_pkg::ACT_LOAD, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0));
    send_beat(cube(samc_pkg::ACT_TEST, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, -1,
                   1));
    write_tolerance(16'hffff);
    send_beat(cube(samc_pkg::ACT_LOAD, 0, 65536, 0, 0, 0));
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_x = 131072; b.box_max_x = 196608; b.move_x = 131072;
    send_beat(b);
    b.box_min_x = -131072; b.box_max_x = -65536; b.move_x = -32'sd2000000;
    send_beat(b);
    write_tolerance(16'h0000);
    send_beat(b);

    for (int k = 0; k < 430; k++) begin
      if (k % 100 == 50) write_tolerance(16'($urandom()));
      if (k == 120) hold_reqs = hold_reqs + 1;
      if (k == 300) drain();
      span = ($urandom_range(0, 1) == 0) ? 300 : 2000000;
      b = make_box(($urandom_range(0, 3) == 0) ? samc_pkg::ACT_LOAD : samc_pkg::ACT_TEST,
                   span);
      send_beat(b);
    end
    drain();
    write_tolerance(16'(samc_pkg::TOL_RESET));
    send_beat(cube(samc_pkg::ACT_LOAD, 0, 65536, 0, 0, 0));
    b = cube(samc_pkg::ACT_TEST, 0, 65536, 0, 0, 0);
    b.box_min_x = 131072; b.box_max_x = 196608; b.move_x = 131072;
    send_beat(b);
    drain();

    $display("covered %0d loads and %0d tests, %0d results checked", n_loads, n_tests,
             sb.checked);
    $display("tolerance swept over zero, full scale, random and reset values");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/samc_pkg.sv
rtl/samc_dp.sv
rtl/samc_ctrl.sv
rtl/swept_aabb_move_clamp.sv
verif/tb_swept_aabb_move_clamp.sv
